FILE: sv/vic_pkg.sv
// vic_pkg: item types and field constants for the vertex id compactor.
// No dependencies; vic_relabel, the top and the test files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package vic_pkg;

    // Width of every vertex id field on the ports
    localparam int FIELD_W = 20;

    typedef logic [FIELD_W-1:0] id_t;

    // One input item: an edge in original ids
    typedef struct packed {
        id_t src_vertex;
        id_t dst_vertex;
    } in_t;

    // One result item: the same edge in dense ids
    typedef struct packed {
        id_t new_src;
        id_t new_dst;
    } out_t;

endpackage

`default_nettype wire

FILE: sv/vic_ram.sv
// vic_ram: generic RAM, one write port and two registered read ports.
// A read in the same cycle as a write to that entry returns the old data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vic_ram #(
    parameter int WIDTH     = 21,
    parameter int ADDR_BITS = 20
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr_a,
    input  wire logic [ADDR_BITS-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]     rd_data_a,
    output logic      [WIDTH-1:0]     rd_data_b
);

    logic [WIDTH-1:0] mem [0:(64'd1 << ADDR_BITS) - 64'd1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: sv/vic_init.sv
// vic_init: post-reset sweep that clears the seen flag of every map entry.
// No dependencies; drives the clear address into the relabel write mux.
`timescale 1ns / 1ps
`default_nettype none

module vic_init #(
    parameter int ADDR_BITS = 20
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    output logic                      clr_busy,
    output logic      [ADDR_BITS-1:0] clr_addr
);

    logic                 busy_reg, busy_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;

    // Walk every address once, then stop
    always_comb begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg) begin
            addr_next = addr_reg + ADDR_BITS'(1);
            if (addr_reg == {ADDR_BITS{1'b1}}) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign clr_busy = busy_reg;
    assign clr_addr = addr_reg;

endmodule

`default_nettype wire

FILE: sv/vic_relabel.sv
// vic_relabel: lookup stage. Issues map reads on accept, resolves both ends
// with write forwarding, allocates dense ids and drives the map write port.
// Depends on vic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vic_relabel #(
    parameter int VERTEX_BITS = 20,
    parameter int ID_BITS     = 20
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input item channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire vic_pkg::in_t             s_item,
    // clear sweep
    input  wire logic                     clr_busy,
    input  wire logic [VERTEX_BITS-1:0]   clr_addr,
    // map memory, entry = {seen, id}
    output logic                          rd_en,
    output logic      [VERTEX_BITS-1:0]   rd_addr_a,
    output logic      [VERTEX_BITS-1:0]   rd_addr_b,
    input  wire logic [ID_BITS:0]         rd_data_a,
    input  wire logic [ID_BITS:0]         rd_data_b,
    output logic                          wr_en,
    output logic      [VERTEX_BITS-1:0]   wr_addr,
    output logic      [ID_BITS:0]         wr_data,
    // resolved item toward the output register
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output vic_pkg::out_t                 res_item
);

    logic                   accept;
    logic                   fire;

    // lookup stage holding one edge while its read data returns
    logic                   p1_valid_reg, p1_valid_next;
    logic [VERTEX_BITS-1:0] p1_src_reg, p1_src_next;
    logic [VERTEX_BITS-1:0] p1_dst_reg, p1_dst_next;

    // write that went out in the cycle the current edge was read
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [VERTEX_BITS-1:0] fwd_addr_reg, fwd_addr_next;
    logic [ID_BITS-1:0]     fwd_id_reg, fwd_id_next;

    // deferred destination write when one edge brings two new vertices
    logic                   pend_valid_reg, pend_valid_next;
    logic [VERTEX_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [ID_BITS-1:0]     pend_id_reg, pend_id_next;

    logic [VERTEX_BITS-1:0] next_id_reg, next_id_next;

    logic                   src_hit, dst_hit, same_vertex;
    logic                   src_new, dst_new, two_writes;
    logic [ID_BITS-1:0]     src_old_id, dst_old_id;
    logic [ID_BITS-1:0]     src_id, dst_id;
    logic [VERTEX_BITS-1:0] dst_alloc;

    assign fire    = p1_valid_reg && res_ready;
    assign s_ready = !clr_busy && (!p1_valid_reg || (fire && !two_writes));
    assign accept  = s_valid && s_ready;

    // Memory read on accept
    assign rd_en     = accept;
    assign rd_addr_a = VERTEX_BITS'(s_item.src_vertex);
    assign rd_addr_b = VERTEX_BITS'(s_item.dst_vertex);

    // Resolve both ends; source first so a self-loop takes one id
    always_comb begin
        src_hit     = fwd_valid_reg && (fwd_addr_reg == p1_src_reg);
        dst_hit     = fwd_valid_reg && (fwd_addr_reg == p1_dst_reg);
        same_vertex = (p1_src_reg == p1_dst_reg);
        src_new     = !(src_hit || rd_data_a[ID_BITS]);
        dst_new     = !same_vertex && !(dst_hit || rd_data_b[ID_BITS]);
        two_writes  = src_new && dst_new;
        src_old_id  = src_hit ? fwd_id_reg : rd_data_a[ID_BITS-1:0];
        dst_old_id  = dst_hit ? fwd_id_reg : rd_data_b[ID_BITS-1:0];
        dst_alloc   = next_id_reg + VERTEX_BITS'(src_new);
        src_id      = src_new ? next_id_reg[ID_BITS-1:0] : src_old_id;
        if (same_vertex) begin
            dst_id = src_id;
        end else if (dst_new) begin
            dst_id = dst_alloc[ID_BITS-1:0];
        end else begin
            dst_id = dst_old_id;
        end
    end

    // Write port: clear sweep, then deferred write, then this edge's first write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = p1_src_reg;
        wr_data = {1'b1, src_id};
        if (clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr;
            wr_data = '0;
        end else if (pend_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = {1'b1, pend_id_reg};
        end else if (fire && (src_new || dst_new)) begin
            wr_en = 1'b1;
            if (!src_new) begin
                wr_addr = p1_dst_reg;
                wr_data = {1'b1, dst_id};
            end
        end
    end

    // Stage, forwarding, deferred write and counter updates
    always_comb begin
        p1_valid_next = p1_valid_reg;
        p1_src_next   = p1_src_reg;
        p1_dst_next   = p1_dst_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
            p1_src_next   = rd_addr_a;
            p1_dst_next   = rd_addr_b;
        end else if (fire) begin
            p1_valid_next = 1'b0;
        end

        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_id_next    = fwd_id_reg;
        if (accept) begin
            fwd_valid_next = wr_en;
            fwd_addr_next  = wr_addr;
            fwd_id_next    = wr_data[ID_BITS-1:0];
        end

        pend_valid_next = fire && two_writes;
        pend_addr_next  = p1_dst_reg;
        pend_id_next    = dst_id;

        next_id_next = next_id_reg;
        if (fire) begin
            next_id_next = next_id_reg + VERTEX_BITS'(src_new) + VERTEX_BITS'(dst_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            next_id_reg    <= '0;
        end else begin
            p1_valid_reg   <= p1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            pend_valid_reg <= pend_valid_next;
            next_id_reg    <= next_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_src_reg    <= p1_src_next;
        p1_dst_reg    <= p1_dst_next;
        fwd_addr_reg  <= fwd_addr_next;
        fwd_id_reg    <= fwd_id_next;
        pend_addr_reg <= pend_addr_next;
        pend_id_reg   <= pend_id_next;
    end

    // Resolved item
    assign res_valid        = p1_valid_reg;
    assign res_item.new_src = vic_pkg::id_t'(src_id);
    assign res_item.new_dst = vic_pkg::id_t'(dst_id);

endmodule

`default_nettype wire

FILE: sv/vertex_id_compactor.sv
// Vertex id compactor: an accepted edge passes the lookup stage and then the
// output register. One edge per cycle while the output is not stalled; an edge
// with two distinct new vertices holds off the next one for its deferred map
// write, since the map memory has a single write port. Reset: next id returns to
// zero and a sweep over all 2**VERTEX_BITS map entries clears the seen flags,
// with s_ready low until it ends. Depends on vic_pkg, vic_ram, vic_init, vic_relabel.
`timescale 1ns / 1ps
`default_nettype none

module vertex_id_compactor #(
    parameter int VERTEX_BITS = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire vic_pkg::in_t  s_item,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vic_pkg::out_t      m_item
);

    // Stored ids never exceed the field width or the vertex count
    localparam int ID_BITS = (VERTEX_BITS < vic_pkg::FIELD_W) ? VERTEX_BITS
                                                              : vic_pkg::FIELD_W;

    logic                   clr_busy;
    logic [VERTEX_BITS-1:0] clr_addr;
    logic                   rd_en, wr_en;
    logic [VERTEX_BITS-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic [ID_BITS:0]       rd_data_a, rd_data_b, wr_data;
    logic                   res_valid, res_ready;
    vic_pkg::out_t          res_item;

    logic                   m_valid_reg, m_valid_next;
    vic_pkg::out_t          m_item_reg, m_item_next;

    vic_init #(
        .ADDR_BITS (VERTEX_BITS)
    ) u_init (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr_busy (clr_busy),
        .clr_addr (clr_addr)
    );

    // Map memory: {seen, dense id} per original vertex
    vic_ram #(
        .WIDTH     (ID_BITS + 1),
        .ADDR_BITS (VERTEX_BITS)
    ) u_map (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    vic_relabel #(
        .VERTEX_BITS (VERTEX_BITS),
        .ID_BITS     (ID_BITS)
    ) u_relabel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .clr_busy  (clr_busy),
        .clr_addr  (clr_addr),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Output register: refills in the cycle it is taken
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            m_item_next  = res_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

FILE: test/vic_checker.sv
// vic_checker: watches both channels of the vertex id compactor, predicts each
// relabeled edge and compares it with the block's result. Depends on vic_pkg.
`timescale 1ns / 1ps

module vic_checker #(
    parameter int VERTEX_BITS = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire vic_pkg::in_t  s_item,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire vic_pkg::out_t m_item,
    output int                 fail_count,
    output int                 pending
);

    // Ids are cut to the address width before lookup; the counter wraps there too
    localparam vic_pkg::id_t ADDR_MASK = vic_pkg::id_t'((64'd1 << VERTEX_BITS) - 1);

    // Dense id of every vertex numbered so far; an absent key means not yet seen
    vic_pkg::id_t  dense_of [vic_pkg::id_t];
    vic_pkg::id_t  next_dense = '0;
    vic_pkg::out_t expected_edges [$];
    int            errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        errors++;
    endtask

    // First-seen numbering of one vertex
    function automatic vic_pkg::id_t dense_id(input vic_pkg::id_t v);
        vic_pkg::id_t key;
        key = v & ADDR_MASK;
        if (!dense_of.exists(key)) begin
            dense_of[key] = next_dense;
            next_dense    = (next_dense + 1'b1) & ADDR_MASK;
        end
        return dense_of[key];
    endfunction

    // Source is numbered before destination, so a new self-loop takes one id
    function automatic vic_pkg::out_t relabel_edge(input vic_pkg::in_t e);
        vic_pkg::out_t r;
        r.new_src = dense_id(e.src_vertex);
        r.new_dst = dense_id(e.dst_vertex);
        return r;
    endfunction

    // Predict on input accept, compare on result accept
    always @(posedge aclk) begin : monitor
        vic_pkg::out_t want;
        if (!aresetn) begin
            dense_of.delete();
            next_dense = '0;
            expected_edges.delete();
        end else begin
            if (s_valid && s_ready)
                expected_edges = {expected_edges, relabel_edge(s_item)};
            if (m_valid && m_ready) begin
                if (expected_edges.size() == 0) begin
                    report_mismatch($sformatf("result (%0d, %0d) with none expected",
                                              m_item.new_src, m_item.new_dst));
                end else begin
                    want = expected_edges.pop_front();
                    if (m_item.new_src !== want.new_src)
                        report_mismatch($sformatf("new_src got %0d want %0d",
                                                  m_item.new_src, want.new_src));
                    if (m_item.new_dst !== want.new_dst)
                        report_mismatch($sformatf("new_dst got %0d want %0d",
                                                  m_item.new_dst, want.new_dst));
                end
            end
        end
        pending <= expected_edges.size();
    end

endmodule

FILE: test/tb.sv
// tb: drives edges into the vertex id compactor with random gaps and stalls and
// gives the verdict. Depends on vic_pkg, vertex_id_compactor and vic_checker.
`timescale 1ns / 1ps

module tb;

    localparam int VERTEX_BITS  = 20;
    localparam int RANDOM_EDGES = 1250;
    localparam int PHASES       = 5;
    // Clearing sweep plus every edge at its longest gap and stall, taken 4 times
    localparam longint CYCLE_LIMIT = 4 * ((64'd1 << VERTEX_BITS) + 1300 * 100);

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    vic_pkg::in_t  s_item;
    logic          m_valid;
    logic          m_ready;
    vic_pkg::out_t m_item;

    int            fail_count;
    int            pending;
    longint        cycles = 0;
    int unsigned   gap_mode = 0;
    int unsigned   rx_mode = 0;
    int unsigned   stall_left = 0;
    vic_pkg::id_t  seen_pool [$];

    vertex_id_compactor #(
        .VERTEX_BITS(VERTEX_BITS)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    vic_checker #(
        .VERTEX_BITS(VERTEX_BITS)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length: mode 0 none, mode 1 mostly short, mode 2 heavy
    function automatic int unsigned pick_gap(input int unsigned mode);
        int unsigned r;
        r = $urandom_range(99);
        case (mode)
            0: return 0;
            1: begin
                if (r < 80) return 0;
                if (r < 97) return $urandom_range(3, 1);
                return $urandom_range(40, 10);
            end
            default: begin
                if (r < 40) return 0;
                if (r < 85) return $urandom_range(4, 1);
                return $urandom_range(40, 5);
            end
        endcase
    endfunction

    // Vertex mix: recent and older revisits, a small hot range, extremes, anything
    function automatic vic_pkg::id_t pick_vertex();
        int unsigned  r;
        int unsigned  n;
        vic_pkg::id_t one_hot;
        r = $urandom_range(99);
        n = seen_pool.size();
        one_hot = vic_pkg::id_t'(1) << $urandom_range(vic_pkg::FIELD_W - 1);
        if (n != 0 && r < 25)
            return seen_pool[n - 1 - $urandom_range((n > 4) ? 3 : n - 1)];
        if (n != 0 && r < 50)
            return seen_pool[$urandom_range(n - 1)];
        if (r < 62)
            return vic_pkg::id_t'($urandom_range(31));
        if (r < 72) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return one_hot;
                default: return ~one_hot;
            endcase
        end
        return vic_pkg::id_t'($urandom);
    endfunction

    // Offer one edge after an idle gap and hold it until accepted
    task automatic send_edge(input vic_pkg::id_t src, input vic_pkg::id_t dst,
                             input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_item.src_vertex <= src;
        s_item.dst_vertex <= dst;
        seen_pool = {seen_pool, src, dst};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off input until every predicted result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Result side stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap(rx_mode);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("vertex_id_compactor: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        vic_pkg::id_t src;
        vic_pkg::id_t dst;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: new self-loops, extreme ids, seen/new mixes, back to back
        send_edge(20'h00000, 20'h00000, 0);
        send_edge(20'hFFFFF, 20'hFFFFF, 0);
        send_edge(20'h00000, 20'hFFFFF, 0);
        send_edge(20'h00001, 20'h00002, 0);
        send_edge(20'h00003, 20'h00000, 0);
        send_edge(20'h00000, 20'h00004, 0);
        send_edge(20'h00002, 20'h00001, 0);
        send_edge(20'h00005, 20'h00005, 0);
        send_edge(20'h80000, 20'h7FFFF, 0);
        send_edge(20'hAAAAA, 20'h55555, 0);
        send_edge(20'h55555, 20'hAAAAA, 0);
        send_edge(20'h7FFFF, 20'h80000, 0);
        send_edge(20'h00006, 20'h00007, 0);
        send_edge(20'h00007, 20'h00006, 0);
        send_edge(20'h00006, 20'h00008, 0);
        send_edge(20'h00009, 20'h00009, 0);
        send_edge(20'h00009, 20'h0000A, 1);
        send_edge(20'h0000B, 20'h0000C, 2);
        send_edge(20'h0000C, 20'h0000B, 0);
        send_edge(20'hFFFFE, 20'h00001, 0);

        // Random phases with changing gap and stall patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            gap_mode = ph % 3;
            rx_mode <= (ph + 1) % 3;
            if (ph == 2)
                wait_drained();
            for (int k = 0; k < RANDOM_EDGES / PHASES; k++) begin
                src = pick_vertex();
                dst = ($urandom_range(9) == 0) ? src : pick_vertex();
                send_edge(src, dst, pick_gap(gap_mode));
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (fail_count == 0)
            $display("vertex_id_compactor: match");
        else
            $display("vertex_id_compactor: mismatch");
        $finish;
    end

endmodule
